@@ sv/assert_macros.svh @@
// Assertion macros shared by the token hash set builder RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, skipped while reset is asserted.
`define THSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define THSB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/thsb_pkg.sv @@
// Package for the token hash set builder: request/result types, FSM states,
// hash constants, character map tables and the modular reduction helper.
// Depends on nothing.
package thsb_pkg;

    // Sizing of the token store
    localparam int MAIL_COUNT = 64;
    localparam int BUCKETS    = 19997;
    localparam int MEM_DEPTH  = MAIL_COUNT * BUCKETS;
    localparam int IDX_W      = $clog2(MEM_DEPTH);

    // Fixed field widths
    localparam int MAIL_W  = 6;
    localparam int HASH_W  = 15;
    localparam int ENTRY_W = HASH_W + 1;
    localparam int MAP_W   = 6;

    // Rolling hash: h = (h * RADIX + map) mod BUCKETS
    localparam int RADIX = 36;
    // Width of h * RADIX + map before reduction
    localparam int X_W   = $clog2(BUCKETS * RADIX);
    // Reciprocal for the quotient estimate; estimate is exact or one low
    localparam int RECIP = (2 ** X_W) / BUCKETS;
    localparam int R_W   = $clog2(RECIP + 1);
    localparam int P_W   = X_W + R_W;

    // Character codes and map offsets
    localparam int CHR_DIG_LO    = 48;
    localparam int CHR_DIG_HI    = 57;
    localparam int CHR_UP_LO     = 65;
    localparam int CHR_UP_HI     = 90;
    localparam int CHR_LO_LO     = 97;
    localparam int CHR_LO_HI     = 122;
    localparam int BKT_UP_OFS    = 55;
    localparam int BKT_LO_OFS    = 87;
    localparam int CHK_DIG_OFS   = 22;
    localparam int MAP_MOD       = 26;

    // Opcodes and result kinds
    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_QUERY    = 1'b1;
    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [MAIL_W-1:0] mail_id;
        logic [7:0]        char_byte;
        logic              text_end;
        logic [HASH_W-1:0] query_bucket;
        logic [HASH_W-1:0] query_check;
    } t_in_req;

    typedef struct packed {
        logic              kind;
        logic [HASH_W-1:0] token_bucket;
        logic [HASH_W-1:0] token_check;
        logic              inserted;
        logic              found;
    } t_out_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_MUL,
        S_HASH_RED,
        S_ADDR,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef logic [255:0][MAP_W-1:0] t_map_tbl;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'(CHR_DIG_LO) && c <= 8'(CHR_DIG_HI)) ||
               (c >= 8'(CHR_UP_LO)  && c <= 8'(CHR_UP_HI))  ||
               (c >= 8'(CHR_LO_LO)  && c <= 8'(CHR_LO_HI));
    endfunction

    // Bucket map: digit d*d, letters (v+10)^2, all mod 26
    function automatic t_map_tbl build_bucket_map();
        t_map_tbl tbl;
        int       v;
        for (int c = 0; c < 256; c++) begin
            v = 0;
            if (c >= CHR_DIG_LO && c <= CHR_DIG_HI) begin
                v = c - CHR_DIG_LO;
            end else if (c >= CHR_UP_LO && c <= CHR_UP_HI) begin
                v = c - BKT_UP_OFS;
            end else if (c >= CHR_LO_LO && c <= CHR_LO_HI) begin
                v = c - BKT_LO_OFS;
            end
            tbl[c] = MAP_W'((v * v) % MAP_MOD);
        end
        return tbl;
    endfunction

    // Check map: digit d+26, letters (v*v+v) mod 26
    function automatic t_map_tbl build_check_map();
        t_map_tbl tbl;
        int       v;
        for (int c = 0; c < 256; c++) begin
            v = 0;
            tbl[c] = '0;
            if (c >= CHR_DIG_LO && c <= CHR_DIG_HI) begin
                tbl[c] = MAP_W'(c - CHK_DIG_OFS);
            end else if (c >= CHR_UP_LO && c <= CHR_UP_HI) begin
                v = c - CHR_UP_LO;
                tbl[c] = MAP_W'((v * v + v) % MAP_MOD);
            end else if (c >= CHR_LO_LO && c <= CHR_LO_HI) begin
                v = c - CHR_LO_LO;
                tbl[c] = MAP_W'((v * v + v) % MAP_MOD);
            end
        end
        return tbl;
    endfunction

    localparam t_map_tbl BUCKET_MAP = build_bucket_map();
    localparam t_map_tbl CHECK_MAP  = build_check_map();

    // Second half of x mod BUCKETS: p holds x * RECIP from the stage before
    function automatic logic [HASH_W-1:0] hash_reduce(input logic [X_W-1:0] x,
                                                      input logic [P_W-1:0] p);
        logic [R_W-1:0] q;
        logic [X_W-1:0] r;
        q = p[P_W-1:X_W];
        r = x - X_W'(q) * X_W'(BUCKETS);
        if (r >= X_W'(BUCKETS)) begin
            r = r - X_W'(BUCKETS);
        end
        return HASH_W'(r);
    endfunction

endpackage

@@ sv/thsb_in_if.sv @@
// Request channel of the token hash set builder: valid, ready, payload.
// Depends on thsb_pkg.
interface thsb_in_if;
    logic              valid;
    logic              ready;
    thsb_pkg::t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/thsb_out_if.sv @@
// Result channel of the token hash set builder: valid, ready, payload.
// Depends on thsb_pkg.
interface thsb_out_if;
    logic               valid;
    logic               ready;
    thsb_pkg::t_out_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/token_hash_set_builder.sv @@
// Top level of the token hash set builder: sequencer, hash datapath, token store.
// Depends on thsb_pkg, thsb_in_if, thsb_out_if and assert_macros.svh.
//
// Takes one request at a time and walks it through a small sequencer around a
// single-port-read, single-port-write token store (64 mails x 19997 buckets,
// 16-bit entries, registered read). After reset the store is swept to
// empty, one entry per cycle; no request is taken then. From acceptance to
// the next acceptance: a separator with no open token goes straight back to
// idle; a letter or digit that does not close a token passes the hash states
// (shift-add and reciprocal multiply, then constant multiply and correction);
// a separator that closes a token, and a query, pass index multiply, store
// read, check/write and result load; a letter or digit with text_end takes all.
// The result register lets a new request in while the last result waits; the
// block stalls only when a new result is ready and the old one is still held.
`include "assert_macros.svh"

module token_hash_set_builder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    thsb_in_if.sink          i_req,
    thsb_out_if.source       o_res
);

    localparam int IDX_W  = thsb_pkg::IDX_W;
    localparam int HASH_W = thsb_pkg::HASH_W;
    localparam int X_W    = thsb_pkg::X_W;
    localparam int P_W    = thsb_pkg::P_W;

    // Sequencer
    thsb_pkg::t_state r_state, n_state;
    logic             w_ready;
    logic             w_load_out;

    // Latched request
    logic                        r_op;
    logic [thsb_pkg::MAIL_W-1:0] r_mail;
    logic [7:0]                  r_char;
    logic                        r_last;
    logic [HASH_W-1:0]           r_qb;
    logic [HASH_W-1:0]           r_qc;

    // Token state
    logic [HASH_W-1:0] r_bh;
    logic [HASH_W-1:0] r_ch;
    logic              r_open;

    // Hash pipeline registers
    logic [X_W-1:0] r_xb, r_xc;
    logic [P_W-1:0] r_pb, r_pc;
    logic [X_W-1:0] w_xb, w_xc;

    // Store access
    logic [thsb_pkg::ENTRY_W-1:0] r_mem [thsb_pkg::MEM_DEPTH];
    logic [thsb_pkg::ENTRY_W-1:0] r_rdata;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_ok;
    logic [IDX_W-1:0]             r_clr_idx;
    logic [HASH_W-1:0]            w_key;
    logic                         w_we;
    logic [IDX_W-1:0]             w_waddr;
    logic [thsb_pkg::ENTRY_W-1:0] w_wdata;
    logic                         w_hit;
    logic                         w_ins;

    // Results
    thsb_pkg::t_out_res r_res;
    thsb_pkg::t_out_res r_out;
    logic               r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thsb_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        w_ready    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            thsb_pkg::S_CLEAR: begin
                if (r_clr_idx == IDX_W'(thsb_pkg::MEM_DEPTH - 1)) begin
                    n_state = thsb_pkg::S_IDLE;
                end
            end
            thsb_pkg::S_IDLE: begin
                w_ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.data.opcode == thsb_pkg::OP_QUERY) begin
                        n_state = thsb_pkg::S_ADDR;
                    end else if (thsb_pkg::is_alnum(i_req.data.char_byte)) begin
                        n_state = thsb_pkg::S_HASH_MUL;
                    end else if (r_open) begin
                        n_state = thsb_pkg::S_ADDR;
                    end
                end
            end
            thsb_pkg::S_HASH_MUL: n_state = thsb_pkg::S_HASH_RED;
            thsb_pkg::S_HASH_RED: begin
                n_state = r_last ? thsb_pkg::S_ADDR : thsb_pkg::S_IDLE;
            end
            thsb_pkg::S_ADDR:  n_state = thsb_pkg::S_READ;
            thsb_pkg::S_READ:  n_state = thsb_pkg::S_CHECK;
            thsb_pkg::S_CHECK: n_state = thsb_pkg::S_EMIT;
            thsb_pkg::S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load_out = 1'b1;
                    n_state    = thsb_pkg::S_IDLE;
                end
            end
            default: n_state = thsb_pkg::S_IDLE;
        endcase
    end

    assign i_req.ready = w_ready;

    // Latch the request on acceptance
    always_ff @(posedge i_clk) begin
        if (w_ready && i_req.valid) begin
            r_op   <= i_req.data.opcode;
            r_mail <= i_req.data.mail_id;
            r_char <= i_req.data.char_byte;
            r_last <= i_req.data.text_end;
            r_qb   <= i_req.data.query_bucket;
            r_qc   <= i_req.data.query_check;
        end
    end

    // First hash stage: h * 36 + map, then multiply by the reciprocal
    assign w_xb = X_W'(r_bh) * X_W'(thsb_pkg::RADIX) + X_W'(thsb_pkg::BUCKET_MAP[r_char]);
    assign w_xc = X_W'(r_ch) * X_W'(thsb_pkg::RADIX) + X_W'(thsb_pkg::CHECK_MAP[r_char]);

    always_ff @(posedge i_clk) begin
        if (r_state == thsb_pkg::S_HASH_MUL) begin
            r_xb <= w_xb;
            r_xc <= w_xc;
            r_pb <= P_W'(w_xb) * P_W'(thsb_pkg::RECIP);
            r_pc <= P_W'(w_xc) * P_W'(thsb_pkg::RECIP);
        end
    end

    // Token state: reduce into the running hashes, clear on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bh   <= '0;
            r_ch   <= '0;
            r_open <= 1'b0;
        end else if (r_state == thsb_pkg::S_HASH_RED) begin
            r_bh   <= thsb_pkg::hash_reduce(r_xb, r_pb);
            r_ch   <= thsb_pkg::hash_reduce(r_xc, r_pc);
            r_open <= 1'b1;
        end else if (r_state == thsb_pkg::S_CHECK && r_op == thsb_pkg::OP_CHAR) begin
            r_bh   <= '0;
            r_ch   <= '0;
            r_open <= 1'b0;
        end
    end

    // Store index: mail * BUCKETS + bucket, with range check
    assign w_key = (r_op == thsb_pkg::OP_QUERY) ? r_qb : r_bh;

    always_ff @(posedge i_clk) begin
        if (r_state == thsb_pkg::S_ADDR) begin
            r_idx <= IDX_W'(r_mail) * IDX_W'(thsb_pkg::BUCKETS) + IDX_W'(w_key);
            r_ok  <= (int'(r_mail) < thsb_pkg::MAIL_COUNT) &&
                     (int'(w_key) < thsb_pkg::BUCKETS);
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (r_state == thsb_pkg::S_CLEAR) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    // Lookup and insert decisions; one request in flight, so the read and
    // write of an entry never overlap with another request's access
    assign w_hit = r_ok && r_rdata[HASH_W] && (r_rdata[HASH_W-1:0] == r_qc);
    assign w_ins = r_ok && !r_rdata[HASH_W];

    // Store write port: sweep or insert
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {1'b1, r_ch};
        if (r_state == thsb_pkg::S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else if (r_state == thsb_pkg::S_CHECK && r_op == thsb_pkg::OP_CHAR) begin
            w_we = w_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Store read port, registered
    always_ff @(posedge i_clk) begin
        if (r_state == thsb_pkg::S_READ && r_ok) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (r_state == thsb_pkg::S_CHECK) begin
            if (r_op == thsb_pkg::OP_QUERY) begin
                r_res.kind         <= thsb_pkg::KIND_ANSWER;
                r_res.token_bucket <= '0;
                r_res.token_check  <= '0;
                r_res.inserted     <= 1'b0;
                r_res.found        <= w_hit;
            end else begin
                r_res.kind         <= thsb_pkg::KIND_TOKEN;
                r_res.token_bucket <= r_bh;
                r_res.token_check  <= r_ch;
                r_res.inserted     <= w_ins;
                r_res.found        <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Checks
    `THSB_ASSERT(a_no_req_in_clear, i_clk, i_rst_n, (r_state == thsb_pkg::S_CLEAR) |-> !w_ready, "request taken during clearing sweep")
    `THSB_ASSERT(a_write_source, i_clk, i_rst_n, w_we |-> ((r_state == thsb_pkg::S_CLEAR) || (r_state == thsb_pkg::S_CHECK && r_op == thsb_pkg::OP_CHAR && r_ok && !r_rdata[HASH_W])), "store written outside sweep or empty-entry insert")
    `THSB_ASSERT(a_hash_range, i_clk, i_rst_n, (int'(r_bh) < thsb_pkg::BUCKETS) && (int'(r_ch) < thsb_pkg::BUCKETS), "running hash out of range")
    `THSB_ASSERT(a_close_clears, i_clk, i_rst_n, (r_state == thsb_pkg::S_CHECK && r_op == thsb_pkg::OP_CHAR) |=> (!r_open && r_bh == '0 && r_ch == '0), "token state not cleared after close")

endmodule
